// File: sv/md5bhc_pkg.sv
// Shared types, constants and round tables for the MD5 block hash core.
package md5bhc_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned RoundW = 6;
    localparam int unsigned IdxW   = 4;
    localparam int unsigned CfgIdxW = 3;

    localparam logic [WordW-1:0] InitAReset = 32'h6745_2301;
    localparam logic [WordW-1:0] InitBReset = 32'hEFCD_AB89;
    localparam logic [WordW-1:0] InitCReset = 32'h98BA_DCFE;
    localparam logic [WordW-1:0] InitDReset = 32'h1032_5476;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] RegInitA = 3'd0;
    localparam logic [CfgIdxW-1:0] RegInitB = 3'd1;
    localparam logic [CfgIdxW-1:0] RegInitC = 3'd2;
    localparam logic [CfgIdxW-1:0] RegInitD = 3'd3;

    localparam logic [RoundW-1:0] LastRound = 6'd63;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ROUND = 4'b0010,
        S_FINAL = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    typedef struct packed {
        logic              wr_word;
        logic              start;
        logic              round;
        logic [RoundW-1:0] round_idx;
        logic [RoundW-1:0] km_idx;
        logic              final_add;
        logic              emit;
    } t_cmd;

    typedef struct packed {
        logic cnt_full;
        logic out_free;
    } t_sts;

    function automatic logic [WordW-1:0] round_const(input logic [RoundW-1:0] idx);
        logic [WordW-1:0] k;
        case (idx)
            6'd0:  k = 32'hD76AA478;  6'd1:  k = 32'hE8C7B756;
            6'd2:  k = 32'h242070DB;  6'd3:  k = 32'hC1BDCEEE;
            6'd4:  k = 32'hF57C0FAF;  6'd5:  k = 32'h4787C62A;
            6'd6:  k = 32'hA8304613;  6'd7:  k = 32'hFD469501;
            6'd8:  k = 32'h698098D8;  6'd9:  k = 32'h8B44F7AF;
            6'd10: k = 32'hFFFF5BB1;  6'd11: k = 32'h895CD7BE;
            6'd12: k = 32'h6B901122;  6'd13: k = 32'hFD987193;
            6'd14: k = 32'hA679438E;  6'd15: k = 32'h49B40821;
            6'd16: k = 32'hF61E2562;  6'd17: k = 32'hC040B340;
            6'd18: k = 32'h265E5A51;  6'd19: k = 32'hE9B6C7AA;
            6'd20: k = 32'hD62F105D;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hD8A1E681;  6'd23: k = 32'hE7D3FBC8;
            6'd24: k = 32'h21E1CDE6;  6'd25: k = 32'hC33707D6;
            6'd26: k = 32'hF4D50D87;  6'd27: k = 32'h455A14ED;
            6'd28: k = 32'hA9E3E905;  6'd29: k = 32'hFCEFA3F8;
            6'd30: k = 32'h676F02D9;  6'd31: k = 32'h8D2A4C8A;
            6'd32: k = 32'hFFFA3942;  6'd33: k = 32'h8771F681;
            6'd34: k = 32'h6D9D6122;  6'd35: k = 32'hFDE5380C;
            6'd36: k = 32'hA4BEEA44;  6'd37: k = 32'h4BDECFA9;
            6'd38: k = 32'hF6BB4B60;  6'd39: k = 32'hBEBFBC70;
            6'd40: k = 32'h289B7EC6;  6'd41: k = 32'hEAA127FA;
            6'd42: k = 32'hD4EF3085;  6'd43: k = 32'h04881D05;
            6'd44: k = 32'hD9D4D039;  6'd45: k = 32'hE6DB99E5;
            6'd46: k = 32'h1FA27CF8;  6'd47: k = 32'hC4AC5665;
            6'd48: k = 32'hF4292244;  6'd49: k = 32'h432AFF97;
            6'd50: k = 32'hAB9423A7;  6'd51: k = 32'hFC93A039;
            6'd52: k = 32'h655B59C3;  6'd53: k = 32'h8F0CCC92;
            6'd54: k = 32'hFFEFF47D;  6'd55: k = 32'h85845DD1;
            6'd56: k = 32'h6FA87E4F;  6'd57: k = 32'hFE2CE6E0;
            6'd58: k = 32'hA3014314;  6'd59: k = 32'h4E0811A1;
            6'd60: k = 32'hF7537E82;  6'd61: k = 32'hBD3AF235;
            6'd62: k = 32'h2AD7D2BB;  default: k = 32'hEB86D391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amount(input logic [RoundW-1:0] idx);
        logic [4:0] s;
        case ({idx[5:4], idx[1:0]})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'hA: s = 5'd16;  4'hB: s = 5'd23;
            4'hC: s = 5'd6;   4'hD: s = 5'd10;  4'hE: s = 5'd15;  default: s = 5'd21;
        endcase
        return s;
    endfunction

    // message word order per round group
    function automatic logic [IdxW-1:0] msg_index(input logic [RoundW-1:0] idx);
        logic [IdxW-1:0] j;
        logic [IdxW-1:0] g;
        j = idx[3:0];
        case (idx[5:4])
            2'd0:    g = j;
            2'd1:    g = IdxW'((j << 2) + j + 4'd1);
            2'd2:    g = IdxW'((j << 1) + j + 4'd5);
            default: g = IdxW'((j << 3) - j);
        endcase
        return g;
    endfunction

    function automatic logic [WordW-1:0] round_func(
        input logic [1:0]       grp,
        input logic [WordW-1:0] b,
        input logic [WordW-1:0] c,
        input logic [WordW-1:0] d
    );
        logic [WordW-1:0] f;
        case (grp)
            2'd0:    f = d ^ (b & (c ^ d));
            2'd1:    f = c ^ (d & (b ^ c));
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

endpackage

// File: sv/md5bhc_ctrl.sv
// Controller: word intake, 64-round sequencing, chaining update and digest hand-off.
module md5bhc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_last_word,
    input  md5bhc_pkg::t_sts     i_sts,
    output logic                 o_stall,
    output md5bhc_pkg::t_cmd     o_cmd
);

    md5bhc_pkg::t_state r_state, n_state;
    logic [md5bhc_pkg::RoundW-1:0] r_round, n_round;
    logic r_last, n_last;
    logic accept;

    assign o_stall = (r_state != md5bhc_pkg::S_IDLE);
    assign accept  = i_valid && (r_state == md5bhc_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_last  = r_last;
        o_cmd   = '0;
        o_cmd.round_idx = r_round;
        unique case (r_state)
            md5bhc_pkg::S_IDLE: begin
                o_cmd.km_idx = '0;
                if (accept) begin
                    o_cmd.wr_word = 1'b1;
                    n_last = i_last_word;
                    if (i_sts.cnt_full) begin
                        o_cmd.start = 1'b1;
                        n_round = '0;
                        n_state = md5bhc_pkg::S_ROUND;
                    end else if (i_last_word) begin
                        n_state = md5bhc_pkg::S_EMIT;
                    end
                end
            end
            md5bhc_pkg::S_ROUND: begin
                o_cmd.round  = 1'b1;
                o_cmd.km_idx = r_round + 1'b1;
                n_round = r_round + 1'b1;
                if (r_round == md5bhc_pkg::LastRound) begin
                    n_state = md5bhc_pkg::S_FINAL;
                end
            end
            md5bhc_pkg::S_FINAL: begin
                o_cmd.final_add = 1'b1;
                n_state = r_last ? md5bhc_pkg::S_EMIT : md5bhc_pkg::S_IDLE;
            end
            md5bhc_pkg::S_EMIT: begin
                // wait until the output register can take the digest
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = md5bhc_pkg::S_IDLE;
                end
            end
            default: n_state = md5bhc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= md5bhc_pkg::S_IDLE;
            r_round <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_last  <= n_last;
        end
    end

endmodule

// File: sv/md5bhc_dpath.sv
// Datapath: init registers, block word store, round unit, chaining words, output register.
module md5bhc_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [md5bhc_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  logic [md5bhc_pkg::WordW-1:0]        i_cfg_data,
    input  logic [md5bhc_pkg::WordW-1:0]        i_message_word,
    input  md5bhc_pkg::t_cmd                    i_cmd,
    input  logic                                i_stall,
    output md5bhc_pkg::t_sts                    o_sts,
    output logic                                o_valid,
    output logic [md5bhc_pkg::WordW-1:0]        o_digest_a,
    output logic [md5bhc_pkg::WordW-1:0]        o_digest_b,
    output logic [md5bhc_pkg::WordW-1:0]        o_digest_c,
    output logic [md5bhc_pkg::WordW-1:0]        o_digest_d
);

    localparam int unsigned W = md5bhc_pkg::WordW;

    logic [W-1:0] r_init_a, r_init_b, r_init_c, r_init_d;
    logic [W-1:0] r_chain_a, r_chain_b, r_chain_c, r_chain_d;
    logic [W-1:0] r_a, r_b, r_c, r_d;
    logic [W-1:0] r_km;
    logic [W-1:0] r_words [16];
    logic [md5bhc_pkg::IdxW-1:0] r_cnt;
    logic         r_out_valid;
    logic [W-1:0] r_out_a, r_out_b, r_out_c, r_out_d;

    logic [W-1:0]   f_val;
    logic [W-1:0]   sum;
    logic [2*W-1:0] rot_ext;
    logic [W-1:0]   rot;
    logic [4:0]     shamt;

    assign f_val   = md5bhc_pkg::round_func(i_cmd.round_idx[5:4], r_b, r_c, r_d);
    assign sum     = r_a + f_val + r_km;
    assign shamt   = md5bhc_pkg::rot_amount(i_cmd.round_idx);
    assign rot_ext = {sum, sum} << shamt;
    assign rot     = rot_ext[2*W-1:W];

    assign o_sts.cnt_full = (r_cnt == '1);
    assign o_sts.out_free = !r_out_valid || !i_stall;

    assign o_valid    = r_out_valid;
    assign o_digest_a = r_out_a;
    assign o_digest_b = r_out_b;
    assign o_digest_c = r_out_c;
    assign o_digest_d = r_out_d;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_a    <= md5bhc_pkg::InitAReset;
            r_init_b    <= md5bhc_pkg::InitBReset;
            r_init_c    <= md5bhc_pkg::InitCReset;
            r_init_d    <= md5bhc_pkg::InitDReset;
            r_chain_a   <= md5bhc_pkg::InitAReset;
            r_chain_b   <= md5bhc_pkg::InitBReset;
            r_chain_c   <= md5bhc_pkg::InitCReset;
            r_chain_d   <= md5bhc_pkg::InitDReset;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    md5bhc_pkg::RegInitA: r_init_a <= i_cfg_data;
                    md5bhc_pkg::RegInitB: r_init_b <= i_cfg_data;
                    md5bhc_pkg::RegInitC: r_init_c <= i_cfg_data;
                    md5bhc_pkg::RegInitD: r_init_d <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.final_add) begin
                r_chain_a <= r_chain_a + r_a;
                r_chain_b <= r_chain_b + r_b;
                r_chain_c <= r_chain_c + r_c;
                r_chain_d <= r_chain_d + r_d;
            end else if (i_cmd.emit) begin
                // next message starts from the current init values
                r_chain_a <= r_init_a;
                r_chain_b <= r_init_b;
                r_chain_c <= r_init_c;
                r_chain_d <= r_init_d;
            end
            if (i_cmd.emit) begin
                r_cnt <= '0;
            end else if (i_cmd.wr_word) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_word) begin
            r_words[r_cnt] <= i_message_word;
        end
        // K + M for the coming round, registered ahead of its use
        r_km <= md5bhc_pkg::round_const(i_cmd.km_idx)
                + r_words[md5bhc_pkg::msg_index(i_cmd.km_idx)];
        if (i_cmd.start) begin
            r_a <= r_chain_a;
            r_b <= r_chain_b;
            r_c <= r_chain_c;
            r_d <= r_chain_d;
        end else if (i_cmd.round) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= r_b + rot;
        end
        if (i_cmd.emit) begin
            r_out_a <= r_chain_a;
            r_out_b <= r_chain_b;
            r_out_c <= r_chain_c;
            r_out_d <= r_chain_d;
        end
    end

endmodule

// File: sv/md5_block_hash_core.sv
// MD5 block hash core: one-round-per-cycle compression over a 32-bit word stream.
//
// Input channel: i_valid / o_stall carry one message word (little-endian) and a
// last-word flag per request. Output channel: o_valid / i_stall carry the four
// digest words, one request per message. Every 16 accepted words form a block.
// A word that does not complete a block is accepted without stalling. The word
// completing a block starts 64 rounds in a single shared round unit (one round
// per cycle) followed by the chaining add, with o_stall high throughout. On a
// last word the controller enters S_EMIT, where the digest is loaded into the
// output register once it is free (after the compression and chaining add if
// that word closed a block); o_valid is high from that load on. A trailing
// partial block is dropped.
// The next message may be fed while a digest waits in the output register; a
// second digest waits until the receiver takes the first, holding o_stall high.
// Init registers are written through i_cfg_we / i_cfg_idx / i_cfg_data and take
// effect when the next digest is emitted; indexes beyond 3 are ignored.
// Synchronous active-low reset restores the standard init values and clears
// the word count and output valid.
module md5_block_hash_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [md5bhc_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  logic [md5bhc_pkg::WordW-1:0]        i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [md5bhc_pkg::WordW-1:0]        i_message_word,
    input  logic                                i_last_word,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [md5bhc_pkg::WordW-1:0]        o_digest_a,
    output logic [md5bhc_pkg::WordW-1:0]        o_digest_b,
    output logic [md5bhc_pkg::WordW-1:0]        o_digest_c,
    output logic [md5bhc_pkg::WordW-1:0]        o_digest_d
);

    md5bhc_pkg::t_cmd cmd;
    md5bhc_pkg::t_sts sts;

    md5bhc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_last_word (i_last_word),
        .i_sts       (sts),
        .o_stall     (o_stall),
        .o_cmd       (cmd)
    );

    md5bhc_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_message_word (i_message_word),
        .i_cmd          (cmd),
        .i_stall        (i_stall),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .o_digest_a     (o_digest_a),
        .o_digest_b     (o_digest_b),
        .o_digest_c     (o_digest_c),
        .o_digest_d     (o_digest_d)
    );

    a_start_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start |=> cmd.round)
        else $error("compression did not begin after block start");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> o_valid)
        else $error("digest load did not raise output valid");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.round || cmd.final_add) |-> o_stall)
        else $error("input not stalled during compression");

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.wr_word, cmd.round, cmd.final_add, cmd.emit}))
        else $error("conflicting datapath commands");

endmodule
